/* src/pls_pkg.sv */
`default_nettype none
package pls_pkg;

  localparam int POS_W = 6;

  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_END   = 3'd1,
    K_INS_POS   = 3'd2,
    K_DEL_FRONT = 3'd3,
    K_DEL_END   = 3'd4,
    K_DEL_POS   = 3'd5,
    K_READ      = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_INVALID = 3'd2,
    ST_BOUNDS  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] last;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage
`default_nettype wire

/* src/pls_if.sv */
`default_nettype none
interface pls_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  slot;
  logic signed [31:0] item_value;

  modport source (output valid, kind, slot, item_value, input ready);
  modport sink   (input valid, kind, slot, item_value, output ready);
endinterface

interface pls_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] element;
  logic        final_res;
  logic [5:0]  length;

  modport source (output valid, status, element, final_res, length, input ready);
  modport sink   (input valid, status, element, final_res, length, output ready);
endinterface
`default_nettype wire

/* src/positional_list_store.sv */
// Ordered list of signed 32-bit values, up to CAPACITY entries.
// cmd channel (sink): kind, slot, item_value. res channel (source): status,
// element, final_res, length. A word moves when valid and ready are high.
// Each non-read command takes effect in the cycle it is accepted; its
// status word is registered and shows on res the next cycle.
// Non-read commands sustain 1 command per cycle while res is taken.
// A read-out of N elements streams N words, one per cycle while res is
// taken, by rotating the cell row toward cell 0; after N steps the row is
// back in order. cmd is not accepted during the read-out; the command
// enters S_READ, which then registers each word (an empty list gives a
// single ST_EMPTY word). The rate is set by the output register: one word
// leaves per cycle while res is taken. When res stalls, the output word
// holds and cmd ready drops; the row does not move until the word is taken.
// Reset (rst, synchronous) empties the list and drops res valid; entry
// contents are not cleared.
`default_nettype none
module positional_list_store #(
  parameter int CAPACITY = 32
) (
  input  wire       clk,
  input  wire       rst,
  pls_cmd_if.sink   cmd,
  pls_res_if.source res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > 6 ? CW : 6) + 1;
  localparam int PW = pls_pkg::POS_W;

  pls_pkg::state_t     state, state_next;
  logic [CW-1:0]       occ, occ_next;
  logic [PW-1:0]       rd_cnt, rd_cnt_next;
  pls_pkg::cell_ctrl_t ctrl;

  logic                ovalid, ovalid_next;
  pls_pkg::status_t    ostatus, ostatus_next;
  logic signed [31:0]  oelem, oelem_next;
  logic                ofinal, ofinal_next;

  logic signed [31:0]  head;
  logic                out_free, accept, rd_last;
  logic [WW-1:0]       slot_w, occ_w;
  logic                full, empty;

  pls_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .ins_d (cmd.item_value),
    .head  (head)
  );

  assign out_free  = !ovalid || res.ready;
  assign cmd.ready = (state == pls_pkg::S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign slot_w    = WW'(cmd.slot);
  assign occ_w     = WW'(occ);
  assign full      = occ_w >= WW'(CAPACITY);
  assign empty     = occ == '0;
  assign rd_last   = rd_cnt == PW'(occ - CW'(1));

  always_comb begin
    state_next   = state;
    occ_next     = occ;
    rd_cnt_next  = rd_cnt;
    ctrl.op      = pls_pkg::CELL_HOLD;
    ctrl.pos     = '0;
    ctrl.last    = PW'(occ - CW'(1));
    ovalid_next  = ovalid && !res.ready;
    ostatus_next = ostatus;
    oelem_next   = oelem;
    ofinal_next  = ofinal;

    unique case (state)
      pls_pkg::S_IDLE: begin
        if (accept) begin
          ovalid_next  = 1'b1;
          ostatus_next = pls_pkg::ST_OK;
          oelem_next   = '0;
          ofinal_next  = 1'b1;
          unique case (cmd.kind)
            pls_pkg::K_INS_FRONT: begin
              if (full) ostatus_next = pls_pkg::ST_FULL;
              else begin
                ctrl.op  = pls_pkg::CELL_INS;
                ctrl.pos = '0;
                occ_next = occ + CW'(1);
              end
            end
            pls_pkg::K_INS_END: begin
              if (full) ostatus_next = pls_pkg::ST_FULL;
              else begin
                ctrl.op  = pls_pkg::CELL_INS;
                ctrl.pos = PW'(occ);
                occ_next = occ + CW'(1);
              end
            end
            pls_pkg::K_INS_POS: begin
              if (cmd.slot == '0) ostatus_next = pls_pkg::ST_INVALID;
              else if (full) ostatus_next = pls_pkg::ST_FULL;
              else if (slot_w > occ_w + WW'(1)) ostatus_next = pls_pkg::ST_BOUNDS;
              else begin
                ctrl.op  = pls_pkg::CELL_INS;
                ctrl.pos = cmd.slot - PW'(1);
                occ_next = occ + CW'(1);
              end
            end
            pls_pkg::K_DEL_FRONT: begin
              if (empty) ostatus_next = pls_pkg::ST_EMPTY;
              else begin
                ctrl.op  = pls_pkg::CELL_DEL;
                ctrl.pos = '0;
                occ_next = occ - CW'(1);
              end
            end
            pls_pkg::K_DEL_END: begin
              if (empty) ostatus_next = pls_pkg::ST_EMPTY;
              else occ_next = occ - CW'(1);
            end
            pls_pkg::K_DEL_POS: begin
              if (cmd.slot == '0) ostatus_next = pls_pkg::ST_INVALID;
              else if (empty) ostatus_next = pls_pkg::ST_EMPTY;
              else if (slot_w > occ_w) ostatus_next = pls_pkg::ST_BOUNDS;
              else begin
                ctrl.op  = pls_pkg::CELL_DEL;
                ctrl.pos = cmd.slot - PW'(1);
                occ_next = occ - CW'(1);
              end
            end
            pls_pkg::K_READ: begin
              if (empty) ostatus_next = pls_pkg::ST_EMPTY;
              else begin
                ovalid_next = 1'b0;
                rd_cnt_next = '0;
                state_next  = pls_pkg::S_READ;
              end
            end
            default: ostatus_next = pls_pkg::ST_INVALID;
          endcase
        end
      end
      pls_pkg::S_READ: begin
        if (out_free) begin
          ovalid_next  = 1'b1;
          ostatus_next = pls_pkg::ST_OK;
          oelem_next   = head;
          ofinal_next  = rd_last;
          ctrl.op      = pls_pkg::CELL_ROT;
          rd_cnt_next  = rd_cnt + PW'(1);
          if (rd_last) state_next = pls_pkg::S_IDLE;
        end
      end
      default: state_next = pls_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pls_pkg::S_IDLE;
      occ    <= '0;
      ovalid <= 1'b0;
      rd_cnt <= '0;
    end else begin
      state  <= state_next;
      occ    <= occ_next;
      ovalid <= ovalid_next;
      rd_cnt <= rd_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ostatus <= ostatus_next;
    oelem   <= oelem_next;
    ofinal  <= ofinal_next;
  end

  assign res.valid     = ovalid;
  assign res.status    = ostatus;
  assign res.element   = oelem;
  assign res.final_res = ofinal;
  assign res.length    = 6'(occ);

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ_w <= WW'(CAPACITY))
    else $error("occupancy above capacity");

  a_cmd_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept && !(cmd.kind == pls_pkg::K_READ && !empty) |=> res.valid && res.final_res)
    else $error("command without final status word");

  a_read_holds_occ: assert property (@(posedge clk) disable iff (rst)
    state == pls_pkg::S_READ |=> occ == $past(occ))
    else $error("occupancy moved during read-out");

  a_nonfinal_in_read: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.final_res |-> state == pls_pkg::S_READ)
    else $error("non-final word outside read-out");
`endif

endmodule
`default_nettype wire

/* src/pls_cell.sv */
`default_nettype none
module pls_cell #(
  parameter int IDX = 0
) (
  input  wire                      clk,
  input  wire pls_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0]  left_d,
  input  wire logic signed [31:0]  right_d,
  input  wire logic signed [31:0]  head_d,
  input  wire logic signed [31:0]  ins_d,
  output logic signed [31:0]       q
);

  localparam logic [pls_pkg::POS_W-1:0] MY_IDX = pls_pkg::POS_W'(IDX);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      pls_pkg::CELL_HOLD: ;
      pls_pkg::CELL_INS: begin
        if (MY_IDX > ctrl.pos) q <= left_d;
        else if (MY_IDX == ctrl.pos) q <= ins_d;
      end
      pls_pkg::CELL_DEL: begin
        if (MY_IDX >= ctrl.pos) q <= right_d;
      end
      pls_pkg::CELL_ROT: begin
        if (MY_IDX < ctrl.last) q <= right_d;
        else if (MY_IDX == ctrl.last) q <= head_d;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/pls_chain.sv */
`default_nettype none
module pls_chain #(
  parameter int CAPACITY = 32
) (
  input  wire                      clk,
  input  wire pls_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0]  ins_d,
  output logic signed [31:0]       head
);

  logic signed [31:0] q [CAPACITY];

  assign head = q[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = ins_d;
    end else begin : g_mid
      assign left_d = q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = q[i+1];
    end

    pls_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (q[0]),
      .ins_d   (ins_d),
      .q       (q[i])
    );
  end

endmodule
`default_nettype wire
